FILE: src/lz77tb_pkg.sv
package lz77tb_pkg;

  localparam int unsigned CNT_W       = 29;
  localparam int unsigned WINDOW_SIZE = 4096;
  localparam int unsigned RING_AW     = $clog2(WINDOW_SIZE);
  localparam int unsigned DIST_W      = RING_AW + 1;
  localparam int unsigned RUN_W       = 5;

  localparam logic [CNT_W-1:0] MAX_DECODED = CNT_W'(268435456);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LITERAL,
    PH_MATCH_HI,
    PH_MATCH_LO
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUNNING,
    ST_COMPLETE,
    ST_TRUNCATED
  } status_t;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_LITERAL,
    CMD_MATCH
  } cmd_kind_t;

  // one command (literal, match or status-only entry) handed from the parser to the output engine
  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         data;
    logic [DIST_W-1:0]  distance;
    logic [RUN_W-1:0]   count;
    logic [CNT_W-1:0]   start;
    logic [CNT_W-1:0]   consumed;
    status_t            status;
  } cmd_t;

endpackage

FILE: src/lz77tb_if.sv
interface lz77tb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input payload_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface lz77tb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last_of_run;
  logic [1:0]  status;
  logic [28:0] bytes_consumed;
  logic [28:0] bytes_produced;

  modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                  output status, output bytes_consumed, output bytes_produced,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input last_of_run,
                input status, input bytes_consumed, input bytes_produced,
                output ready);
endinterface

FILE: src/lz77tb_cmd_fifo.sv
module lz77tb_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lz77tb_pkg::cmd_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output lz77tb_pkg::cmd_t  head
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lz77tb_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/lz77tb_front.sv
module lz77tb_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lz77tb_pkg::CNT_W-1:0]       cfg_wdata,
  lz77tb_in_if.sink                          in_ch,
  input  logic                               q_full,
  output logic                               q_push,
  output lz77tb_pkg::cmd_t                   q_data
);

  localparam int unsigned CW = lz77tb_pkg::CNT_W;
  localparam int unsigned RW = lz77tb_pkg::RUN_W;
  localparam int unsigned DW = lz77tb_pkg::DIST_W;

  logic [CW-1:0]        raw_size_r;
  logic                 cfg_hold_r;
  logic [CW-1:0]        pc_r, pc_b, pc_nxt;
  logic [CW-1:0]        cc_r, cc_b, cc_nxt;
  logic [CW-1:0]        room_r, room_b, room_nxt;
  logic                 atl_r, atl_b, atl_nxt;
  logic [7:0]           sh_r, sh_b, sh_nxt;
  logic [3:0]           bits_r, bits_b, bits_nxt;
  logic [7:0]           held_r, held_b, held_nxt;
  lz77tb_pkg::phase_t   ph_r, ph_b, ph_nxt;
  lz77tb_pkg::status_t  fin_r, fin_b, fin_nxt;
  logic [CW-1:0]        limit;
  logic [RW-1:0]        cnt;
  logic [RW-1:0]        run_n;
  logic [DW-1:0]        distance;
  logic                 tok;
  logic                 accept;

  assign in_ch.ready = !q_full && !cfg_hold_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;
  assign limit       = (raw_size_r > lz77tb_pkg::MAX_DECODED) ? lz77tb_pkg::MAX_DECODED
                                                              : raw_size_r;

  always_comb begin
    if (in_ch.first_byte) begin
      pc_b   = '0;
      cc_b   = '0;
      room_b = limit;
      atl_b  = (limit == '0);
      sh_b   = '0;
      bits_b = '0;
      held_b = '0;
      ph_b   = lz77tb_pkg::PH_TAG;
      fin_b  = lz77tb_pkg::ST_RUNNING;
    end else begin
      pc_b   = pc_r;
      cc_b   = cc_r;
      room_b = room_r;
      atl_b  = atl_r;
      sh_b   = sh_r;
      bits_b = bits_r;
      held_b = held_r;
      ph_b   = ph_r;
      fin_b  = fin_r;
    end

    pc_nxt   = pc_b;
    cc_nxt   = cc_b;
    room_nxt = room_b;
    atl_nxt  = atl_b;
    sh_nxt   = sh_b;
    bits_nxt = bits_b;
    held_nxt = held_b;
    ph_nxt   = ph_b;
    fin_nxt  = fin_b;
    tok      = 1'b0;
    run_n    = RW'(1);
    distance = {1'b0, held_b[7:4], in_ch.payload_byte};
    if (distance == '0) begin
      distance = DW'(lz77tb_pkg::WINDOW_SIZE);
    end
    cnt = {1'b0, held_b[3:0]} + RW'(3);

    q_data.kind     = lz77tb_pkg::CMD_STATUS;
    q_data.data     = '0;
    q_data.distance = distance;

    if (fin_b == lz77tb_pkg::ST_RUNNING && atl_b) begin
      fin_nxt = lz77tb_pkg::ST_COMPLETE;
    end

    if (fin_nxt == lz77tb_pkg::ST_RUNNING) begin
      cc_nxt = (cc_b != '1) ? cc_b + CW'(1) : cc_b;
      case (ph_b)
        lz77tb_pkg::PH_TAG: begin
          sh_nxt   = {in_ch.payload_byte[6:0], 1'b0};
          bits_nxt = 4'd7;
          ph_nxt   = in_ch.payload_byte[7] ? lz77tb_pkg::PH_MATCH_HI : lz77tb_pkg::PH_LITERAL;
        end
        lz77tb_pkg::PH_LITERAL: begin
          q_data.kind = lz77tb_pkg::CMD_LITERAL;
          q_data.data = in_ch.payload_byte;
          tok         = 1'b1;
        end
        lz77tb_pkg::PH_MATCH_HI: begin
          held_nxt = in_ch.payload_byte;
          ph_nxt   = lz77tb_pkg::PH_MATCH_LO;
        end
        lz77tb_pkg::PH_MATCH_LO: begin
          q_data.kind = lz77tb_pkg::CMD_MATCH;
          tok         = 1'b1;
          // clamp the run to what is left before the declared size
          if (room_b[CW-1:RW] == '0 && room_b[RW-1:0] < cnt) begin
            run_n = room_b[RW-1:0];
          end else begin
            run_n = cnt;
          end
        end
        default: begin
          ph_nxt = lz77tb_pkg::PH_TAG;
        end
      endcase

      if (tok) begin
        room_nxt = room_b - CW'(run_n);
        pc_nxt   = pc_b + CW'(run_n);
        atl_nxt  = (room_nxt == '0);
        if (atl_nxt) begin
          fin_nxt = lz77tb_pkg::ST_COMPLETE;
        end else if (bits_b == '0) begin
          ph_nxt = lz77tb_pkg::PH_TAG;
        end else begin
          ph_nxt   = sh_b[7] ? lz77tb_pkg::PH_MATCH_HI : lz77tb_pkg::PH_LITERAL;
          sh_nxt   = {sh_b[6:0], 1'b0};
          bits_nxt = bits_b - 4'd1;
        end
      end

      if (fin_nxt == lz77tb_pkg::ST_RUNNING && in_ch.last_byte) begin
        fin_nxt = lz77tb_pkg::ST_TRUNCATED;
      end
    end

    q_data.count    = run_n;
    q_data.start    = pc_b;
    q_data.consumed = cc_nxt;
    q_data.status   = fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_size_r <= CW'(1);
      cfg_hold_r <= 1'b0;
      pc_r       <= '0;
      cc_r       <= '0;
      room_r     <= CW'(1);
      atl_r      <= 1'b0;
      sh_r       <= '0;
      bits_r     <= '0;
      held_r     <= '0;
      ph_r       <= lz77tb_pkg::PH_TAG;
      fin_r      <= lz77tb_pkg::ST_RUNNING;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        raw_size_r <= cfg_wdata;
      end
      if (accept) begin
        pc_r   <= pc_nxt;
        cc_r   <= cc_nxt;
        room_r <= room_nxt;
        atl_r  <= atl_nxt;
        sh_r   <= sh_nxt;
        bits_r <= bits_nxt;
        held_r <= held_nxt;
        ph_r   <= ph_nxt;
        fin_r  <= fin_nxt;
      end else begin
        // refresh headroom so a new raw_size is seen before the next item
        room_r <= limit - pc_r;
        atl_r  <= (pc_r >= limit);
      end
    end
  end

endmodule

FILE: src/lz77tb_back.sv
module lz77tb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  lz77tb_pkg::cmd_t  q_head,
  output logic              q_pop,
  lz77tb_out_if.source      out_ch
);

  localparam int unsigned CW = lz77tb_pkg::CNT_W;
  localparam int unsigned AW = lz77tb_pkg::RING_AW;
  localparam int unsigned DW = lz77tb_pkg::DIST_W;
  localparam int unsigned RW = lz77tb_pkg::RUN_W;

  logic [7:0]           ring_mem [lz77tb_pkg::WINDOW_SIZE];
  logic [7:0]           rdata_r;

  logic                 cmd_valid_r;
  lz77tb_pkg::cmd_t     cmd_r;
  logic [RW-1:0]        rem_r;
  logic [CW-1:0]        pos_r;

  logic                 s2_valid_r;
  logic                 s2_wr_r;
  logic                 s2_mem_r;
  logic                 s2_zero_r;
  logic                 s2_hit_r;
  logic [7:0]           s2_fwd_r;
  logic [7:0]           s2_byte_r;
  logic                 s2_last_r;
  lz77tb_pkg::status_t  s2_status_r;
  logic [CW-1:0]        s2_cons_r;
  logic [CW-1:0]        s2_prod_r;
  logic [AW-1:0]        s2_addr_r;

  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_bv_r;
  logic                 out_last_r;
  lz77tb_pkg::status_t  out_status_r;
  logic [CW-1:0]        out_cons_r;
  logic [CW-1:0]        out_prod_r;

  logic                 s2_adv;
  logic                 issue;
  logic                 last_issue;
  logic                 load;
  logic                 is_status;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 rd_zero;
  logic                 rd_hit;
  logic [7:0]           s2_value;
  logic                 ring_we;

  assign s2_adv     = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign issue      = cmd_valid_r && (!s2_valid_r || s2_adv);
  assign last_issue = (rem_r <= RW'(1));
  assign load       = q_valid && (!cmd_valid_r || (issue && last_issue));
  assign q_pop      = load;
  assign is_status  = (cmd_r.kind == lz77tb_pkg::CMD_STATUS);

  assign rd_en   = issue && (cmd_r.kind == lz77tb_pkg::CMD_MATCH);
  assign rd_addr = pos_r[AW-1:0] - cmd_r.distance[AW-1:0];
  assign rd_zero = (pos_r[CW-1:DW] == '0) && (pos_r[DW-1:0] < cmd_r.distance);
  // byte written this cycle is not yet visible to the registered read
  assign rd_hit  = s2_adv && s2_wr_r && (s2_addr_r == rd_addr);

  assign s2_value = !s2_mem_r ? s2_byte_r :
                    s2_zero_r ? 8'd0 :
                    s2_hit_r  ? s2_fwd_r : rdata_r;
  assign ring_we  = s2_adv && s2_wr_r;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[s2_addr_r] <= s2_value;
    end
    if (rd_en) begin
      rdata_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cmd_valid_r <= 1'b1;
      end else if (issue && last_issue) begin
        cmd_valid_r <= 1'b0;
      end
      if (issue) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= q_head;
      rem_r <= q_head.count;
      pos_r <= q_head.start;
    end else if (issue) begin
      rem_r <= rem_r - RW'(1);
      if (!is_status) begin
        pos_r <= pos_r + CW'(1);
      end
    end

    if (issue) begin
      s2_wr_r     <= !is_status;
      s2_mem_r    <= (cmd_r.kind == lz77tb_pkg::CMD_MATCH);
      s2_zero_r   <= rd_zero;
      s2_hit_r    <= rd_hit;
      s2_fwd_r    <= s2_value;
      s2_byte_r   <= is_status ? 8'd0 : cmd_r.data;
      s2_last_r   <= last_issue;
      s2_status_r <= last_issue ? cmd_r.status : lz77tb_pkg::ST_RUNNING;
      s2_cons_r   <= cmd_r.consumed;
      s2_prod_r   <= is_status ? pos_r : pos_r + CW'(1);
      s2_addr_r   <= pos_r[AW-1:0];
    end

    if (s2_adv) begin
      out_byte_r   <= s2_value;
      out_bv_r     <= s2_wr_r;
      out_last_r   <= s2_last_r;
      out_status_r <= s2_status_r;
      out_cons_r   <= s2_cons_r;
      out_prod_r   <= s2_prod_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.byte_valid     = out_bv_r;
  assign out_ch.last_of_run    = out_last_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.bytes_consumed = out_cons_r;
  assign out_ch.bytes_produced = out_prod_r;

endmodule

FILE: src/lz77_tag_bit_ring_decoder.sv
// channel   dir  handshake              payload
// in_ch     in   valid/ready            payload_byte, first_byte, last_byte
// out_ch    out  valid/ready            out_byte, byte_valid, last_of_run, status,
//                                       bytes_consumed, bytes_produced
// cfg       in   cfg_we (write only)    cfg_wdata = raw_size
//
// The parser takes one item per cycle while the command queue has room and no cfg write holds ready low.
// The output engine gives one result per cycle while out_ch is not stalled: a match of n
// bytes (up to 18) gives n results, any other item one; ring reads are pipelined and forwarded.
// An accepted item passes the queue, the command register, stage s2 and the output register.
// rst_n clears counters and control only; the 4096-byte ring is never cleared.
// in_ch.ready drops when the queue is full and in the cycle after each cfg write.
module lz77_tag_bit_ring_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lz77tb_pkg::CNT_W-1:0]  cfg_wdata,
  lz77tb_in_if.sink                     in_ch,
  lz77tb_out_if.source                  out_ch
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  lz77tb_pkg::cmd_t  q_push_data;
  lz77tb_pkg::cmd_t  q_head;

  lz77tb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  lz77tb_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  lz77tb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: test/lz77_tag_bit_ring_decoder_tb.sv
`timescale 1ns / 1ps

module lz77_tag_bit_ring_decoder_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int DIRECTED_ITEMS = 27;
  localparam int RANDOM_ITEMS = 415;
  localparam int QUIET_TAIL = 40;
  localparam int unsigned CW = lz77tb_pkg::CNT_W;
  localparam int unsigned AW = lz77tb_pkg::RING_AW;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                last_of_run;
    lz77tb_pkg::status_t status;
    logic [CW-1:0]       consumed;
    logic [CW-1:0]       produced;
  } decoded_t;

  class ring_decoder_scoreboard;
    logic [7:0]          ring [lz77tb_pkg::WINDOW_SIZE];
    logic [CW-1:0]       produced;
    logic [CW-1:0]       consumed;
    logic [7:0]          tag_bits;
    logic [3:0]          tag_left;
    lz77tb_pkg::phase_t  phase;
    logic [7:0]          held;
    lz77tb_pkg::status_t finish;
    logic [CW-1:0]       raw_size;
    decoded_t            plain_q[$];
    int                  errors;

    function new();
      clear_stream();
      raw_size = CW'(1);
      errors = 0;
    endfunction

    function void clear_stream();
      produced = '0;
      consumed = '0;
      tag_bits = '0;
      tag_left = '0;
      phase = lz77tb_pkg::PH_TAG;
      held = '0;
      finish = lz77tb_pkg::ST_RUNNING;
    endfunction

    function logic [CW-1:0] limit();
      return (raw_size > lz77tb_pkg::MAX_DECODED) ? lz77tb_pkg::MAX_DECODED : raw_size;
    endfunction

    function int pending();
      return plain_q.size();
    endfunction

    function void push_plain(logic [7:0] b);
      ring[produced[AW-1:0]] = b;
      produced++;
      plain_q.push_back('{b, 1'b1, 1'b0, lz77tb_pkg::ST_RUNNING, consumed, produced});
    endfunction

    function void next_phase();
      if (tag_left == 0) begin
        phase = lz77tb_pkg::PH_TAG;
      end else begin
        phase = tag_bits[7] ? lz77tb_pkg::PH_MATCH_HI : lz77tb_pkg::PH_LITERAL;
        tag_bits = tag_bits << 1;
        tag_left--;
      end
    endfunction

    function void token_done();
      if (produced >= limit()) finish = lz77tb_pkg::ST_COMPLETE;
      else next_phase();
    endfunction

    function void note_byte(logic [7:0] b, logic is_first, logic is_last);
      int               n0;
      int unsigned      cnt;
      logic [12:0]      distance;
      logic [CW-1:0]    room;
      logic [CW-1:0]    idx;
      decoded_t         tail;
      n0 = plain_q.size();
      if (is_first) clear_stream();
      if (finish == lz77tb_pkg::ST_RUNNING && produced >= limit())
        finish = lz77tb_pkg::ST_COMPLETE;
      if (finish == lz77tb_pkg::ST_RUNNING) begin
        if (consumed != '1) consumed++;
        case (phase)
          lz77tb_pkg::PH_TAG: begin
            tag_bits = b;
            tag_left = 4'd8;
            next_phase();
          end
          lz77tb_pkg::PH_LITERAL: begin
            push_plain(b);
            token_done();
          end
          lz77tb_pkg::PH_MATCH_HI: begin
            held = b;
            phase = lz77tb_pkg::PH_MATCH_LO;
          end
          default: begin
            distance = {1'b0, held[7:4], b};
            if (distance == 0) distance = 13'd4096;
            cnt = int'(held[3:0]) + 3;
            room = limit() - produced;
            if (cnt > room) cnt = 32'(room);
            for (int i = 0; i < cnt; i++) begin
              idx = produced - CW'(distance);
              push_plain((CW'(distance) <= produced) ? ring[idx[AW-1:0]] : 8'h00);
            end
            token_done();
          end
        endcase
        if (finish == lz77tb_pkg::ST_RUNNING && is_last) finish = lz77tb_pkg::ST_TRUNCATED;
      end
      if (plain_q.size() == n0)
        plain_q.push_back('{8'h00, 1'b0, 1'b0, lz77tb_pkg::ST_RUNNING, consumed, produced});
      tail = plain_q.pop_back();
      tail.last_of_run = 1'b1;
      tail.status = finish;
      plain_q.push_back(tail);
    endfunction

    function void check_result(decoded_t got);
      decoded_t want;
      if (plain_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t unexpected result: byte=%02h v=%0b last=%0b st=%0d cons=%0d prod=%0d",
                   $time, got.out_byte, got.byte_valid, got.last_of_run, got.status,
                   got.consumed, got.produced);
        return;
      end
      want = plain_q.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.last_of_run !== want.last_of_run || got.status !== want.status ||
          got.consumed !== want.consumed || got.produced !== want.produced) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t mismatch exp: byte=%02h v=%0b last=%0b st=%0d cons=%0d prod=%0d",
                   $time, want.out_byte, want.byte_valid, want.last_of_run, want.status,
                   want.consumed, want.produced);
          $display("%0t          act: byte=%02h v=%0b last=%0b st=%0d cons=%0d prod=%0d",
                   $time, got.out_byte, got.byte_valid, got.last_of_run, got.status,
                   got.consumed, got.produced);
        end
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  lz77tb_in_if  in_ch();
  lz77tb_out_if out_ch();

  lz77_tag_bit_ring_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  ring_decoder_scoreboard sb = new();
  bit bursts_on;
  int sent_items;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 6) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= int'($urandom_range(0, 8));
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.out_byte, out_ch.byte_valid, out_ch.last_of_run,
                        lz77tb_pkg::status_t'(out_ch.status), out_ch.bytes_consumed,
                        out_ch.bytes_produced});
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic is_first, input logic is_last);
    int gap;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      gap = int'($urandom_range(1, 9));
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload_byte <= b;
    in_ch.first_byte <= is_first;
    in_ch.last_byte <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b, is_first, is_last);
    sent_items++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_raw_size(input logic [CW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.raw_size = v;
  endtask

  // well-formed token stream, optionally cut short; last_byte on the final item sent
  task automatic send_stream(input int n_tags, input bit cut);
    logic [7:0] bytes_q[$];
    logic [7:0] tag;
    logic [7:0] b1;
    logic [7:0] b2;
    int made;
    int stop;
    made = 0;
    repeat (n_tags) begin
      tag = 8'($urandom);
      bytes_q.push_back(tag);
      for (int i = 7; i >= 0; i--) begin
        if (!tag[i]) begin
          bytes_q.push_back(8'($urandom));
          made++;
        end else begin
          case ($urandom_range(0, 9))
            0: begin
              b1 = {4'h0, 4'($urandom)};
              b2 = 8'h00;
            end
            1, 2: begin
              b1 = 8'($urandom);
              b2 = 8'($urandom);
            end
            default: begin
              b1 = {4'h0, 4'($urandom)};
              b2 = 8'($urandom_range(1, (made > 255) ? 255 : ((made > 0) ? made : 1)));
            end
          endcase
          bytes_q.push_back(b1);
          bytes_q.push_back(b2);
          made += int'(b1[3:0]) + 3;
        end
      end
    end
    stop = cut ? int'($urandom_range(1, bytes_q.size())) : bytes_q.size();
    for (int k = 0; k < stop; k++) send_item(bytes_q[k], k == 0, k == stop - 1);
  endtask

  initial begin
    logic [CW-1:0] size_pick;
    in_ch.valid = 1'b0;
    in_ch.payload_byte = 8'h00;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    bursts_on = 1'b1;
    sent_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // literals at the byte extremes, far match before any data, overlapping copy,
    // zero distance meaning a full window
    write_raw_size(lz77tb_pkg::MAX_DECODED);
    send_item(8'h40, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h7f, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h01, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h01, 1'b0, 1'b0);
    send_item(8'h0f, 1'b0, 1'b0);
    send_item(8'h05, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h10, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h1e, 1'b0, 1'b0);
    drain_results();

    // limit lowered below what is already produced, then a byte after the finish
    write_raw_size(CW'(10));
    send_item(8'h33, 1'b0, 1'b0);
    send_item(8'h44, 1'b0, 1'b0);
    drain_results();

    write_raw_size(CW'(1));
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h9c, 1'b0, 1'b0);
    send_item(8'h12, 1'b0, 1'b0);
    drain_results();

    // input ends on the tag byte
    write_raw_size(lz77tb_pkg::MAX_DECODED);
    send_item(8'h80, 1'b1, 1'b1);

    while (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 9))
        0: size_pick = lz77tb_pkg::MAX_DECODED;
        1: size_pick = CW'(1);
        2: size_pick = CW'($urandom_range(1, int'(lz77tb_pkg::MAX_DECODED)));
        default: size_pick = CW'($urandom_range(20, 300));
      endcase
      write_raw_size(size_pick);
      bursts_on = (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS - 60) &&
                  ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) != 0) begin
          send_stream(int'($urandom_range(1, 4)), $urandom_range(0, 9) < 4);
        end else begin
          repeat ($urandom_range(1, 12))
            send_item(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
        end
      end
    end

    drain_results();
    repeat (QUIET_TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
